// ----- src/salc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salc_pkg
// Types and constants shared by the cache tag model front end, back end and top level.
// ----------------------------------------------------------------------------
package salc_pkg;

    typedef enum logic [2:0] {
        REG_INDEX_MODE      = 3'd0,
        REG_LOG_PAGE_SIZE   = 3'd1,
        REG_LOG_PHYS_PAGES  = 3'd2,
        REG_LOG_ROWS        = 3'd3,
        REG_LOG_BLOCK_BYTES = 3'd4,
        REG_WAYS            = 3'd5
    } t_reg;

    typedef enum logic [1:0] {
        MODE_PIPT     = 2'd0,
        MODE_VIPT     = 2'd1,
        MODE_VIVT     = 2'd2,
        MODE_PIPT_ALT = 2'd3
    } t_mode;

    typedef struct packed {
        logic [1:0] index_mode;
        logic [4:0] log_page_size;
        logic [5:0] log_phys_pages;
        logic [3:0] log_rows;
        logic [3:0] log_block_bytes;
        logic [3:0] ways;
    } t_cfg;

    // Classified request handed from the front end to the back end
    typedef struct packed {
        logic        cmd;
        t_mode       mode;
        logic [31:0] tag;
        logic [31:0] tmask;
        logic [3:0]  walk_log;
        logic [3:0]  log_rows;
        logic [4:0]  ways;
    } t_req;

    typedef struct packed {
        logic        hit;
        logic [63:0] read_count;
        logic [63:0] write_count;
        logic [63:0] read_hit_count;
        logic [63:0] write_hit_count;
    } t_res;

    localparam logic [31:0] ALIGN_MASK = 32'hFFFF_FFFC;

    // One way of a tag row: valid, tag, LRU stamp
    localparam int WAY_BITS  = 97;
    localparam int VALID_POS = 96;
    localparam int TAG_HI    = 95;
    localparam int TAG_LO    = 64;
    localparam int STAMP_HI  = 63;

endpackage

// ----- src/salc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salc_front
// Accepts an access, hashes its page number and forms tag, row and alias scope.
// ----------------------------------------------------------------------------
module salc_front #(
    parameter int LOG_MAX_ROWS = 10,
    parameter int MAX_WAYS     = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  salc_pkg::t_cfg       i_cfg,
    input  logic                 i_hold,
    input  logic                 i_push,
    input  logic                 i_command,
    input  logic [31:0]          i_address,
    output logic                 o_full,
    output logic                 o_req_vld,
    output salc_pkg::t_req       o_req,
    output logic [((LOG_MAX_ROWS > 0) ? LOG_MAX_ROWS : 1)-1:0] o_row,
    input  logic                 i_req_full
);

    localparam int RIW = (LOG_MAX_ROWS > 0) ? LOG_MAX_ROWS : 1;

    typedef enum logic [1:0] {F_IDLE, F_MIX1, F_MIX2, F_SEND} t_fstate;

    t_fstate     r_state, n_state;
    logic        r_cmd, n_cmd;
    logic [31:0] r_va, n_va;
    logic [31:0] r_k, n_k;

    logic [31:0] vpn, k1, k2, k3, k4, k5, k6, keep, pa, off_mask, tag, tmask, row_src;
    logic [4:0]  lp;
    logic [3:0]  lb, lr, walk_log;
    logic [4:0]  nw;
    logic [5:0]  sh, d;
    salc_pkg::t_mode mode;
    logic [RIW-1:0] row;

    always_comb begin
        lp   = i_cfg.log_page_size;
        lb   = i_cfg.log_block_bytes;
        lr   = (i_cfg.log_rows > 4'(LOG_MAX_ROWS)) ? 4'(LOG_MAX_ROWS) : i_cfg.log_rows;
        if (i_cfg.ways == 4'd0) begin
            nw = 5'd1;
        end else if (5'(i_cfg.ways) > 5'(MAX_WAYS)) begin
            nw = 5'(MAX_WAYS);
        end else begin
            nw = 5'(i_cfg.ways);
        end
        mode = salc_pkg::t_mode'(i_cfg.index_mode);
        if (mode == salc_pkg::MODE_PIPT_ALT) begin
            mode = salc_pkg::MODE_PIPT;
        end

        // Integer mixing hash, split over three steps
        vpn = r_va >> lp;
        k1  = ~vpn + (vpn << 15);
        k2  = k1 ^ 32'($signed(k1) >>> 12);
        k3  = r_k + (r_k << 2);
        k4  = k3 ^ 32'($signed(k3) >>> 4);
        k5  = r_k + (r_k << 3) + (r_k << 11);
        k6  = k5 ^ 32'($signed(k5) >>> 16);

        if (i_cfg.log_phys_pages == 6'd0) begin
            keep = 32'd0;
        end else if (i_cfg.log_phys_pages >= 6'd32) begin
            keep = '1;
        end else begin
            keep = (32'd1 << i_cfg.log_phys_pages[4:0]) - 32'd1;
        end
        off_mask = (32'd1 << lp) - 32'd1;
        pa       = ((k6 & keep) << lp) | (r_va & off_mask);

        sh = 6'(lb) + 6'(lr);
        case (mode)
            salc_pkg::MODE_VIPT: begin
                tag     = pa >> lb;
                row_src = r_va;
            end
            salc_pkg::MODE_VIVT: begin
                tag     = r_va >> sh;
                row_src = r_va;
            end
            default: begin
                tag     = pa >> sh;
                row_src = pa;
            end
        endcase
        row = RIW'(row_src >> lb) & RIW'((32'd1 << lr) - 32'd1);

        // Rows that may hold an alias of the same physical block
        d = 6'(lp) - sh;
        if (6'(lp) < sh) begin
            walk_log = (5'(lp) > 5'(lb)) ? 4'(5'(lp) - 5'(lb)) : 4'd0;
            tmask    = 32'd0;
        end else begin
            walk_log = lr;
            tmask    = (32'd1 << d[4:0]) - 32'd1;
        end
        if (mode == salc_pkg::MODE_VIPT) begin
            tmask = '1;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_va    = r_va;
        n_k     = r_k;
        case (r_state)
            F_IDLE: begin
                if (i_push && !i_hold) begin
                    n_cmd   = i_command;
                    n_va    = i_address & salc_pkg::ALIGN_MASK;
                    n_state = F_MIX1;
                end
            end
            F_MIX1: begin
                n_k     = k2;
                n_state = F_MIX2;
            end
            F_MIX2: begin
                n_k     = k4;
                n_state = F_SEND;
            end
            F_SEND: begin
                if (!i_req_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_cmd <= n_cmd;
        r_va  <= n_va;
        r_k   <= n_k;
    end

    assign o_full         = (r_state != F_IDLE) || i_hold;
    assign o_req_vld      = (r_state == F_SEND);
    assign o_req.cmd      = r_cmd;
    assign o_req.mode     = mode;
    assign o_req.tag      = tag;
    assign o_req.tmask    = tmask;
    assign o_req.walk_log = walk_log;
    assign o_req.log_rows = lr;
    assign o_req.ways     = nw;
    assign o_row          = row;

endmodule

// ----- src/salc_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salc_queue
// Two-entry request queue between the front end and the back end.
// ----------------------------------------------------------------------------
module salc_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ----- src/salc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salc_back
// Tag store, lookup, alias invalidation, LRU victim choice and counters.
// ----------------------------------------------------------------------------
module salc_back #(
    parameter int LOG_MAX_ROWS = 10,
    parameter int MAX_WAYS     = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_vld,
    input  salc_pkg::t_req       i_req,
    input  logic [((LOG_MAX_ROWS > 0) ? LOG_MAX_ROWS : 1)-1:0] i_row,
    output logic                 o_req_pop,
    output logic                 o_clearing,
    input  logic                 i_pop,
    output logic                 o_empty,
    output salc_pkg::t_res       o_res
);

    localparam int ROWS = 1 << LOG_MAX_ROWS;
    localparam int RIW  = (LOG_MAX_ROWS > 0) ? LOG_MAX_ROWS : 1;
    localparam int CW   = RIW + 1;
    localparam int WIW  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

    typedef logic [MAX_WAYS-1:0][salc_pkg::WAY_BITS-1:0] t_line_row;

    typedef enum logic [3:0] {
        B_CLEAR, B_IDLE, B_LOOK, B_WALK, B_REREAD, B_LATCH, B_SCAN, B_FILL, B_DONE
    } t_bstate;

    t_line_row mem [ROWS];
    t_line_row r_rd;

    t_bstate        r_state, n_state;
    logic [RIW-1:0] r_clr, n_clr;
    salc_pkg::t_req r_req, n_req;
    logic [RIW-1:0] r_row, n_row;
    logic [63:0]    r_clock, n_clock;
    logic           r_hit, n_hit;
    t_line_row      r_buf, n_buf;
    logic [CW-1:0]  r_walk, n_walk;
    logic [WIW-1:0] r_way, n_way;
    logic [63:0]    r_best, n_best;
    logic [WIW-1:0] r_victim, n_victim;
    logic [63:0]    r_rtot, n_rtot, r_wtot, n_wtot, r_rhit, n_rhit, r_whit, n_whit;
    salc_pkg::t_res r_out, n_out;
    logic           r_out_vld, n_out_vld;

    logic           we;
    logic [RIW-1:0] wa, ra;
    t_line_row      wd;
    logic           found;
    logic [WIW-1:0] hw;
    logic [CW-1:0]  stride, rows, nxt;
    logic [salc_pkg::WAY_BITS-1:0] line;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        r_rd <= mem[ra];
    end

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_req     = r_req;
        n_row     = r_row;
        n_clock   = r_clock;
        n_hit     = r_hit;
        n_buf     = r_buf;
        n_walk    = r_walk;
        n_way     = r_way;
        n_best    = r_best;
        n_victim  = r_victim;
        n_rtot    = r_rtot;
        n_wtot    = r_wtot;
        n_rhit    = r_rhit;
        n_whit    = r_whit;
        n_out     = r_out;
        n_out_vld = r_out_vld;
        o_req_pop = 1'b0;
        we        = 1'b0;
        wa        = r_row;
        ra        = r_row;
        wd        = r_rd;
        found     = 1'b0;
        hw        = '0;
        stride    = CW'(1) << r_req.walk_log;
        rows      = CW'(1) << r_req.log_rows;
        nxt       = r_walk + stride;
        line      = r_buf[r_way];

        if (i_pop && r_out_vld) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            B_CLEAR: begin
                we    = 1'b1;
                wa    = r_clr;
                wd    = '0;
                n_clr = r_clr + RIW'(1);
                if (r_clr == RIW'(ROWS - 1)) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (i_req_vld) begin
                    o_req_pop = 1'b1;
                    n_req     = i_req;
                    n_row     = i_row;
                    ra        = i_row;
                    n_clock   = r_clock + 64'd1;
                    n_state   = B_LOOK;
                end
            end
            B_LOOK: begin
                for (int i = 0; i < MAX_WAYS; i++) begin
                    if (!found && (5'(i) < r_req.ways) && r_rd[i][salc_pkg::VALID_POS] &&
                        (r_rd[i][salc_pkg::TAG_HI:salc_pkg::TAG_LO] == r_req.tag)) begin
                        found = 1'b1;
                        hw    = WIW'(i);
                    end
                end
                n_hit = found;
                if (found) begin
                    wd[hw][salc_pkg::STAMP_HI:0] = r_clock;
                    we      = 1'b1;
                    n_state = B_DONE;
                end else if (r_req.mode != salc_pkg::MODE_PIPT) begin
                    n_walk  = {1'b0, r_row} & (stride - CW'(1));
                    ra      = RIW'(n_walk);
                    n_state = B_WALK;
                end else begin
                    n_buf    = r_rd;
                    n_way    = '0;
                    n_best   = '1;
                    n_victim = '0;
                    n_state  = B_SCAN;
                end
            end
            B_WALK: begin
                // drop every line that may alias the same physical block
                for (int i = 0; i < MAX_WAYS; i++) begin
                    if ((5'(i) < r_req.ways) && r_rd[i][salc_pkg::VALID_POS] &&
                        ((r_rd[i][salc_pkg::TAG_HI:salc_pkg::TAG_LO] & r_req.tmask) ==
                         (r_req.tag & r_req.tmask))) begin
                        wd[i] = '0;
                    end
                end
                we = 1'b1;
                wa = RIW'(r_walk);
                if (nxt < rows) begin
                    ra     = RIW'(nxt);
                    n_walk = nxt;
                end else begin
                    n_state = B_REREAD;
                end
            end
            B_REREAD: begin
                n_state = B_LATCH;
            end
            B_LATCH: begin
                n_buf    = r_rd;
                n_way    = '0;
                n_best   = '1;
                n_victim = '0;
                n_state  = B_SCAN;
            end
            B_SCAN: begin
                if (!line[salc_pkg::VALID_POS]) begin
                    n_victim = r_way;
                    n_state  = B_FILL;
                end else begin
                    if (line[salc_pkg::STAMP_HI:0] < r_best) begin
                        n_best   = line[salc_pkg::STAMP_HI:0];
                        n_victim = r_way;
                    end
                    if (5'(r_way) + 5'd1 == r_req.ways) begin
                        n_state = B_FILL;
                    end else begin
                        n_way = r_way + WIW'(1);
                    end
                end
            end
            B_FILL: begin
                wd           = r_buf;
                wd[r_victim] = {1'b1, r_req.tag, r_clock};
                we           = 1'b1;
                n_state      = B_DONE;
            end
            B_DONE: begin
                if (!r_out_vld) begin
                    if (r_req.cmd) begin
                        n_wtot = r_wtot + 64'd1;
                        n_whit = r_whit + 64'(r_hit);
                    end else begin
                        n_rtot = r_rtot + 64'd1;
                        n_rhit = r_rhit + 64'(r_hit);
                    end
                    n_out.hit             = r_hit;
                    n_out.read_count      = n_rtot;
                    n_out.write_count     = n_wtot;
                    n_out.read_hit_count  = n_rhit;
                    n_out.write_hit_count = n_whit;
                    n_out_vld             = 1'b1;
                    n_state               = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_CLEAR;
            r_clr     <= '0;
            r_clock   <= '0;
            r_rtot    <= '0;
            r_wtot    <= '0;
            r_rhit    <= '0;
            r_whit    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_clock   <= n_clock;
            r_rtot    <= n_rtot;
            r_wtot    <= n_wtot;
            r_rhit    <= n_rhit;
            r_whit    <= n_whit;
            r_out_vld <= n_out_vld;
        end
        r_req    <= n_req;
        r_row    <= n_row;
        r_hit    <= n_hit;
        r_buf    <= n_buf;
        r_walk   <= n_walk;
        r_way    <= n_way;
        r_best   <= n_best;
        r_victim <= n_victim;
        r_out    <= n_out;
    end

    assign o_clearing = (r_state == B_CLEAR);
    assign o_empty    = !r_out_vld;
    assign o_res      = r_out;

endmodule

// ----- src/set_assoc_lru_cache_tag_model_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tag_model_top
// Tag model of one set-associative LRU cache with PIPT, VIPT and VIVT indexing.
// ----------------------------------------------------------------------------
// The front end holds one access at a time. After reset the tag store is
// cleared one row a cycle, all 2**LOG_MAX_ROWS rows, with full held high. An
// accepted access passes two page hash steps and a send into the request
// queue, which waits while it is full, with full held high. The back end reads
// one tag row and writes one per cycle through one read and one write port:
// a hit goes through take, look up and record, a PIPT miss adds a victim scan
// of 1 to ways lines and a fill, and a VIPT/VIVT miss first walks the alias
// rows, then re-reads the row. The walk covers one row when the page spans the
// whole index, else 2**(log_rows - log_page_size + log_block_bytes) rows, and
// every row when the block is at least as large as the page. A result waiting
// to be popped holds the back end. The front end takes the next access while
// the back end still works on the previous one.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_tag_model_top #(
    parameter int LOG_MAX_ROWS = 10,
    parameter int MAX_WAYS     = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  logic        i_command,
    input  logic [31:0] i_address,
    output logic        empty,
    input  logic        pop,
    output logic        o_hit,
    output logic [63:0] o_read_count,
    output logic [63:0] o_write_count,
    output logic [63:0] o_read_hit_count,
    output logic [63:0] o_write_hit_count
);

    localparam int RIW = (LOG_MAX_ROWS > 0) ? LOG_MAX_ROWS : 1;
    localparam int QW  = $bits(salc_pkg::t_req) + RIW;

    salc_pkg::t_cfg r_cfg;
    salc_pkg::t_reg reg_sel;
    logic           cfg_wr;

    salc_pkg::t_req front_req, back_req;
    logic [RIW-1:0] front_row, back_row;
    logic           front_vld, q_full, q_empty, q_pop, clearing;
    salc_pkg::t_res res;

    assign pready  = 1'b1;
    assign reg_sel = salc_pkg::t_reg'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.index_mode      <= 2'd0;
            r_cfg.log_page_size   <= 5'd12;
            r_cfg.log_phys_pages  <= 6'd16;
            r_cfg.log_rows        <= 4'd10;
            r_cfg.log_block_bytes <= 4'd5;
            r_cfg.ways            <= 4'd2;
        end else if (cfg_wr) begin
            case (reg_sel)
                salc_pkg::REG_INDEX_MODE:      r_cfg.index_mode      <= pwdata[1:0];
                salc_pkg::REG_LOG_PAGE_SIZE:   r_cfg.log_page_size   <= pwdata[4:0];
                salc_pkg::REG_LOG_PHYS_PAGES:  r_cfg.log_phys_pages  <= pwdata[5:0];
                salc_pkg::REG_LOG_ROWS:        r_cfg.log_rows        <= pwdata[3:0];
                salc_pkg::REG_LOG_BLOCK_BYTES: r_cfg.log_block_bytes <= pwdata[3:0];
                salc_pkg::REG_WAYS:            r_cfg.ways            <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            salc_pkg::REG_INDEX_MODE:      prdata = 32'(r_cfg.index_mode);
            salc_pkg::REG_LOG_PAGE_SIZE:   prdata = 32'(r_cfg.log_page_size);
            salc_pkg::REG_LOG_PHYS_PAGES:  prdata = 32'(r_cfg.log_phys_pages);
            salc_pkg::REG_LOG_ROWS:        prdata = 32'(r_cfg.log_rows);
            salc_pkg::REG_LOG_BLOCK_BYTES: prdata = 32'(r_cfg.log_block_bytes);
            salc_pkg::REG_WAYS:            prdata = 32'(r_cfg.ways);
            default:                       prdata = 32'd0;
        endcase
    end

    salc_front #(
        .LOG_MAX_ROWS (LOG_MAX_ROWS),
        .MAX_WAYS     (MAX_WAYS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_hold     (clearing),
        .i_push     (push),
        .i_command  (i_command),
        .i_address  (i_address),
        .o_full     (full),
        .o_req_vld  (front_vld),
        .o_req      (front_req),
        .o_row      (front_row),
        .i_req_full (q_full)
    );

    salc_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_vld),
        .i_data  ({front_req, front_row}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  ({back_req, back_row})
    );

    salc_back #(
        .LOG_MAX_ROWS (LOG_MAX_ROWS),
        .MAX_WAYS     (MAX_WAYS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_vld  (!q_empty),
        .i_req      (back_req),
        .i_row      (back_row),
        .o_req_pop  (q_pop),
        .o_clearing (clearing),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_res      (res)
    );

    assign o_hit             = res.hit;
    assign o_read_count      = res.read_count;
    assign o_write_count     = res.write_count;
    assign o_read_hit_count  = res.read_hit_count;
    assign o_write_hit_count = res.write_hit_count;

endmodule

// ----- src/salc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salc_checker
// Port-level checks on the cache tag model, bound to its top level.
// ----------------------------------------------------------------------------
module salc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic        o_hit,
    input logic [63:0] o_read_count,
    input logic [63:0] o_write_count,
    input logic [63:0] o_read_hit_count,
    input logic [63:0] o_write_hit_count
);

    // store is cleared after reset, so no request may enter
    a_full_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> full)
        else $error("full low straight after reset");

    a_empty_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result shown straight after reset");

    // one result register: a popped result leaves nothing behind
    a_pop_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty) |=> empty)
        else $error("result still shown after pop");

    a_hits_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_read_hit_count <= o_read_count) &&
                   (o_write_hit_count <= o_write_count) &&
                   (o_read_count != 64'd0 || o_write_count != 64'd0))
        else $error("hit counters exceed request counters");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty && $stable(o_hit) && $stable(o_read_count))
        else $error("stalled result changed");

endmodule

bind set_assoc_lru_cache_tag_model_top salc_checker u_salc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .full              (full),
    .empty             (empty),
    .pop               (pop),
    .o_hit             (o_hit),
    .o_read_count      (o_read_count),
    .o_write_count     (o_write_count),
    .o_read_hit_count  (o_read_hit_count),
    .o_write_hit_count (o_write_hit_count)
);
